/* hdl/cenc_subsample_sequencer_assert.svh */
// Assertion macros for the subsample sequencer.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef CENC_SUBSAMPLE_SEQUENCER_ASSERT_SVH
`define CENC_SUBSAMPLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cenc_sseq_pkg.sv */
// Types, codes and scheme helpers of the subsample sequencer.
// No dependencies; used by cenc_subsample_sequencer.
package cenc_sseq_pkg;

  localparam int LenBits   = 24;
  localparam int IvBits    = 64;
  localparam int CfgBits   = 64;
  localparam int CfgIdxBits = 3;

  localparam logic [31:0] FourccCenc = 32'h63656e63;
  localparam logic [31:0] FourccCens = 32'h63656e73;
  localparam logic [31:0] FourccCbc1 = 32'h63626331;
  localparam logic [31:0] FourccCbcs = 32'h63626373;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_WHOLE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_INVALID     = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SCHEME   = 3'd0,
    CFG_CRYPT    = 3'd1,
    CFG_SKIP     = 3'd2,
    CFG_PACKET   = 3'd3,
    CFG_IV_UPPER = 3'd4,
    CFG_IV_LOWER = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_SCALE,
    S_RESULT
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [LenBits-1:0] plain_len;
    logic [LenBits-1:0] cipher_len;
    logic               is_last;
    logic [IvBits-1:0]  tail_upper;
    logic [IvBits-1:0]  tail_lower;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               use_cbc;
    logic [LenBits-1:0] copy_bytes;
    logic [LenBits-1:0] decrypt_bytes;
    logic [3:0]         start_offset;
    logic [IvBits-1:0]  iv_upper_out;
    logic [IvBits-1:0]  iv_lower_out;
    logic               sample_done;
  } out_item_t;

  // Pattern is forbidden for cenc and cbc1; unknown fourcc is unsupported.
  function automatic status_e scheme_status(logic [31:0] scheme, logic [3:0] crypt,
                                            logic [3:0] skip);
    logic pat;
    pat = (crypt != 4'd0) || (skip != 4'd0);
    if (scheme == FourccCenc || scheme == FourccCbc1) begin
      return pat ? STATUS_INVALID : STATUS_OK;
    end else if (scheme == FourccCens || scheme == FourccCbcs) begin
      return STATUS_OK;
    end
    return STATUS_UNSUPPORTED;
  endfunction

  function automatic logic scheme_cbc(logic [31:0] scheme);
    return (scheme == FourccCbc1) || (scheme == FourccCbcs);
  endfunction

endpackage

/* hdl/cenc_subsample_sequencer.sv */
// Control sequencer of a common-encryption sample decryptor (cenc, cens, cbc1, cbcs).
// Turns start, subsample and whole-sample items into copy/decrypt lengths plus IV
// and advances the IV between subsamples. Every item, whatever its command, runs
// through the same bit-serial restoring divider that forms the cens pattern count
// (encrypted 16-byte blocks divided by crypt_blocks + skip_blocks), producing one
// quotient bit per step; a scale state then scales the quotient and a result state
// forms the result. The package length width is LenBits = 24. A new item is taken
// only once the previous result has been loaded into the output register.
// in_stall_o stays high from acceptance until the result is loaded into the output
// register. A finished result that is still waiting downstream does not block the
// next acceptance. Errors (scheme, pattern, overrun, misaligned cbc1, leftover bytes)
// stick until the next start item. The user must write configuration through the
// plain port and only while the block has nothing in flight; it is not enforced.
// Depends on cenc_sseq_pkg and cenc_subsample_sequencer_assert.svh.
`include "cenc_subsample_sequencer_assert.svh"

module cenc_subsample_sequencer (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [cenc_sseq_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [cenc_sseq_pkg::CfgBits-1:0]       cfg_wdata_i,
  // input items
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  cenc_sseq_pkg::in_item_t                 in_item_i,
  // result items
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output cenc_sseq_pkg::out_item_t                out_item_o
);
  import cenc_sseq_pkg::*;

  // Block count of the protected part and the divider built around it.
  localparam int NbBits  = LenBits - 4;
  localparam int CntBits = $clog2(NbBits);
  localparam int IncBits = NbBits + 5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0]        scheme_q;
  logic [3:0]         crypt_q;
  logic [3:0]         skip_q;
  logic [LenBits-1:0] packet_q;
  logic [IvBits-1:0]  iv_upper_q;
  logic [IvBits-1:0]  iv_lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q   <= FourccCenc;
      crypt_q    <= '0;
      skip_q     <= '0;
      packet_q   <= '0;
      iv_upper_q <= '0;
      iv_lower_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCHEME:   scheme_q   <= cfg_wdata_i[31:0];
        CFG_CRYPT:    crypt_q    <= cfg_wdata_i[3:0];
        CFG_SKIP:     skip_q     <= cfg_wdata_i[3:0];
        CFG_PACKET:   packet_q   <= cfg_wdata_i[LenBits-1:0];
        CFG_IV_UPPER: iv_upper_q <= cfg_wdata_i;
        CFG_IV_LOWER: iv_lower_q <= cfg_wdata_i;
        default: ;  // indexes past the list write nothing
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [CntBits-1:0]   cnt_q;
  logic                 accept;
  logic                 div_step;
  logic                 scale_step;
  logic                 res_load;
  logic                 out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DIVIDE;
      S_DIVIDE: if (cnt_q == CntBits'(NbBits - 1)) state_d = S_SCALE;
      S_SCALE:  state_d = S_RESULT;
      S_RESULT: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept     = (state_q == S_IDLE) && in_valid_i;
    div_step   = (state_q == S_DIVIDE);
    scale_step = (state_q == S_SCALE);
    // Hold the result while the previous one is still stalled downstream.
    res_load   = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (div_step) begin
        cnt_q <= cnt_q + CntBits'(1);
      end
    end
  end

  // Capture the item; it stays put until the result is formed.
  in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: one quotient bit per cycle, restoring.
  // quot_q starts as the dividend and shifts quotient bits in from the bottom.
  // ---------------------------------------------------------------------------
  logic [NbBits-1:0]  quot_q;
  logic [4:0]         rem_q;
  logic [4:0]         pat_size;
  logic [5:0]         trial;
  logic               trial_ge;
  logic [IncBits-1:0] inc_q;
  logic [IncBits-1:0] scaled;

  assign pat_size = 5'(crypt_q) + 5'(skip_q);
  assign trial    = {rem_q, quot_q[NbBits-1]};
  assign trial_ge = (trial >= 6'(pat_size));

  // cens counter advance: whole patterns times crypt, plus crypt if the partial
  // pattern reaches past its encrypted blocks.
  always_comb begin
    scaled = IncBits'(quot_q) * IncBits'(crypt_q);
    if (rem_q >= 5'(crypt_q)) begin
      scaled = scaled + IncBits'(crypt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quot_q <= in_item_i.cipher_len[LenBits-1:4];
      rem_q  <= '0;
    end else if (div_step) begin
      quot_q <= {quot_q[NbBits-2:0], trial_ge};
      rem_q  <= trial_ge ? 5'(trial - 6'(pat_size)) : trial[4:0];
    end
    if (scale_step) begin
      inc_q <= scaled;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample state and result
  // ---------------------------------------------------------------------------
  logic [IvBits-1:0]      iv_hi_q, iv_hi_d;
  logic [IvBits-1:0]      iv_ctr_q, iv_ctr_d;
  logic [3:0]             phase_q, phase_d;
  logic [LenBits-1:0]     left_q, left_d;
  status_e                err_q, err_d;
  out_item_t              res;
  out_item_t              out_item_q;

  logic [LenBits-1:0]     clr_l;
  logic [LenBits-1:0]     prot_l;
  logic [LenBits-1:0]     rest1;
  logic [LenBits-1:0]     left_nx;
  logic [LenBits:0]       phase_sum;
  status_e                sstat;
  status_e                err_eff;
  logic                   is_cenc, is_cens, is_cbc1;
  logic                   overrun;
  logic                   bad_cens;
  logic                   bad_cbc1;

  assign clr_l     = item_q.plain_len;
  assign prot_l    = item_q.cipher_len;
  assign rest1     = left_q - clr_l;
  assign left_nx   = rest1 - prot_l;
  assign phase_sum = (LenBits + 1)'(phase_q) + (LenBits + 1)'(prot_l);
  assign sstat     = scheme_status(scheme_q, crypt_q, skip_q);
  assign err_eff   = (err_q == STATUS_OK) ? sstat : err_q;
  assign is_cenc   = (scheme_q == FourccCenc);
  assign is_cens   = (scheme_q == FourccCens);
  assign is_cbc1   = (scheme_q == FourccCbc1);
  assign overrun   = (left_q < clr_l) || (rest1 < prot_l);
  assign bad_cens  = (prot_l != '0) && is_cens && (pat_size == 5'd0);
  assign bad_cbc1  = (prot_l != '0) && is_cbc1 &&
                     ((prot_l < LenBits'(16)) || (prot_l[3:0] != 4'd0));

  always_comb begin
    iv_hi_d  = iv_hi_q;
    iv_ctr_d = iv_ctr_q;
    phase_d  = phase_q;
    left_d   = left_q;
    err_d    = err_q;

    // Report the IV in force before this item's update; a start item reports the IV it loads.
    res.status        = err_q;
    res.use_cbc       = scheme_cbc(scheme_q);
    res.copy_bytes    = '0;
    res.decrypt_bytes = '0;
    res.start_offset  = phase_q;
    res.iv_upper_out  = iv_hi_q;
    res.iv_lower_out  = iv_ctr_q;
    res.sample_done   = 1'b0;

    unique case (item_q.cmd)
      CMD_START: begin
        err_d            = sstat;
        iv_hi_d          = iv_upper_q;
        iv_ctr_d         = iv_lower_q;
        phase_d          = 4'd0;
        left_d           = packet_q;
        res.status       = sstat;
        res.start_offset = 4'd0;
        res.iv_upper_out = iv_upper_q;
        res.iv_lower_out = iv_lower_q;
        res.sample_done  = (sstat != STATUS_OK);
      end
      CMD_NONE: ;  // report only
      default: begin  // subsample or whole sample
        err_d           = err_eff;
        res.status      = err_eff;
        res.sample_done = 1'b1;
        if (err_eff != STATUS_OK) begin
          // sticky error: lengths stay zero, nothing advances
        end else if (item_q.cmd == CMD_WHOLE) begin
          left_d            = '0;
          res.decrypt_bytes = left_q;
        end else if (overrun || bad_cens || bad_cbc1) begin
          err_d      = STATUS_INVALID;
          res.status = STATUS_INVALID;
        end else begin
          if (prot_l != '0) begin
            if (is_cenc) begin
              iv_ctr_d = iv_ctr_q + IvBits'(phase_sum >> 4);
              phase_d  = phase_sum[3:0];
            end else if (is_cens) begin
              iv_ctr_d = iv_ctr_q + IvBits'(inc_q);
              phase_d  = phase_sum[3:0];
            end else if (is_cbc1) begin
              iv_hi_d  = item_q.tail_upper;
              iv_ctr_d = item_q.tail_lower;
            end
          end
          left_d            = left_nx;
          res.copy_bytes    = clr_l;
          res.decrypt_bytes = prot_l;
          res.sample_done   = item_q.is_last;
          // Leftover payload after the last subsample.
          if (item_q.is_last && (left_nx != '0)) begin
            err_d      = STATUS_INVALID;
            res.status = STATUS_INVALID;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_hi_q  <= '0;
      iv_ctr_q <= '0;
      phase_q  <= '0;
      left_q   <= '0;
      err_q    <= STATUS_OK;
    end else if (res_load) begin
      iv_hi_q  <= iv_hi_d;
      iv_ctr_q <= iv_ctr_d;
      phase_q  <= phase_d;
      left_q   <= left_d;
      err_q    <= err_d;
    end
  end

  // Output register: load on result, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSS_ASSERT_NEXT(a_accept_starts_divide, accept, state_q == S_DIVIDE,
                   "accepted item did not enter the divider")
  `CSS_ASSERT_NOW(a_div_count_bound, state_q == S_DIVIDE, cnt_q <= CntBits'(NbBits - 1),
                  "divider ran past its last quotient bit")
  `CSS_ASSERT_NEXT(a_error_sticky,
                   res_load && (item_q.cmd != CMD_START) && (err_q != STATUS_OK),
                   err_q == $past(err_q), "sticky error changed without a start item")
  `CSS_ASSERT_NOW(a_no_result_overwrite, res_load && out_valid_q, !out_stall_i,
                  "result loaded over a stalled output item")

endmodule
